// ===== rtl/core/efd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efd_pkg
// Shared types, constants and the CRC-8 step for the escaped frame decoder.
// ---------------------------------------------------------------------------
package efd_pkg;

    localparam int LENGTH_WIDTH = 16;
    localparam int BYTE_WIDTH = 8;
    localparam int STATUS_WIDTH = 2;
    localparam int CFG_INDEX_WIDTH = 8;

    // Output tdata carries payload_byte, status and payload_length, padded to bytes.
    localparam int OUT_FIELDS_WIDTH = BYTE_WIDTH + STATUS_WIDTH + LENGTH_WIDTH;
    localparam int OUT_TDATA_WIDTH = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;
    localparam int OUT_PAD_WIDTH = OUT_TDATA_WIDTH - OUT_FIELDS_WIDTH;

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

    localparam logic [BYTE_WIDTH-1:0] CRC_POLY = 8'h8C;
    localparam logic [BYTE_WIDTH-1:0] CRC_LSB_MASK = 8'h01;

    // Result queue sizing: one accepted byte pushes at most two results.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
    localparam int FIFO_LEVEL_WIDTH = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_PUSH = 2;

    localparam logic [BYTE_WIDTH-1:0] START_MARKER_RESET = 8'd2;
    localparam logic [BYTE_WIDTH-1:0] END_MARKER_RESET = 8'd3;
    localparam logic [BYTE_WIDTH-1:0] ESCAPE_MARKER_RESET = 8'd16;
    localparam logic [BYTE_WIDTH-1:0] ESCAPE_MASK_RESET = 8'd32;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_MARKER = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_MARKER = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ESCAPE_MARKER = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ESCAPE_MASK = 8'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK = 2'd0,
        STATUS_CRC_MISMATCH = 2'd1,
        STATUS_ESCAPE_AT_END = 2'd2,
        STATUS_EMPTY_FRAME = 2'd3
    } status_t;

    typedef struct packed {
        logic kind;
        logic [BYTE_WIDTH-1:0] payload_byte;
        status_t status;
        logic [LENGTH_WIDTH-1:0] payload_length;
        logic last;
    } result_t;

    // Results written into the queue in the same cycle; first goes out before second.
    typedef struct packed {
        logic [1:0] count;
        result_t first;
        result_t second;
    } fifo_push_t;

    // Reflected CRC-8, one byte per call.
    function automatic logic [BYTE_WIDTH-1:0] crc8_update(
        input logic [BYTE_WIDTH-1:0] crc,
        input logic [BYTE_WIDTH-1:0] data
    );
        logic [BYTE_WIDTH-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_WIDTH; i++)
        begin
            if ((c & CRC_LSB_MASK) != '0)
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/efd_result_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efd_result_fifo
// Small result queue that takes up to two results per cycle and gives one.
// ---------------------------------------------------------------------------
module efd_result_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  efd_pkg::fifo_push_t                 push,
    input  logic                                pop,
    output efd_pkg::result_t                    head,
    output logic                                head_valid,
    output logic [efd_pkg::FIFO_LEVEL_WIDTH-1:0] level
);

    efd_pkg::result_t entry_reg [efd_pkg::FIFO_DEPTH];

    logic [efd_pkg::FIFO_PTR_WIDTH-1:0]   wr_ptr_reg;
    logic [efd_pkg::FIFO_PTR_WIDTH-1:0]   wr_ptr_next;
    logic [efd_pkg::FIFO_PTR_WIDTH-1:0]   rd_ptr_reg;
    logic [efd_pkg::FIFO_PTR_WIDTH-1:0]   rd_ptr_next;
    logic [efd_pkg::FIFO_LEVEL_WIDTH-1:0] level_reg;
    logic [efd_pkg::FIFO_LEVEL_WIDTH-1:0] level_next;
    logic [efd_pkg::FIFO_PTR_WIDTH-1:0]   wr_ptr_plus1;
    logic                                 do_pop;

    assign do_pop = pop && (level_reg != '0);
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + efd_pkg::FIFO_PTR_WIDTH'(push.count);
        rd_ptr_next = rd_ptr_reg + efd_pkg::FIFO_PTR_WIDTH'(do_pop);
        level_next = level_reg + efd_pkg::FIFO_LEVEL_WIDTH'(push.count)
                     - efd_pkg::FIFO_LEVEL_WIDTH'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    assign head = entry_reg[rd_ptr_reg];
    assign head_valid = (level_reg != '0);
    assign level = level_reg;

endmodule

// ===== rtl/core/escaped_frame_decoder_crc8.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// escaped_frame_decoder_crc8
// Byte-stuffing deframer with a reflected CRC-8 check and frame status.
// ---------------------------------------------------------------------------
// The results pushed when a byte is accepted are registered in the result
// queue and reach the master side once the results ahead of them are out.
// Throughput: one byte per cycle, set by the combinational decode and CRC step;
// a buffer's last byte adds a status beat, which the four-entry result queue
// absorbs. The slave side takes a byte while at least two queue slots are free.
// Reset: asynchronous and active low; markers return to their defaults and the
// frame state clears at once, with no clearing pass.
// ---------------------------------------------------------------------------
module escaped_frame_decoder_crc8 (
    input  logic                                clk,
    input  logic                                rst_n,
    // Slave side: tdata = raw_byte[7:0]; tlast = buffer_end.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,
    input  logic                                s_axis_tlast,
    // Master side: tdata = payload_byte[7:0], status[9:8],
    // payload_length[25:10], zero padding above; tuser = kind; tlast = last.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [efd_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [efd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [7:0]                          cfg_data
);

    // Configuration registers.
    logic [7:0] start_marker_reg;
    logic [7:0] end_marker_reg;
    logic [7:0] escape_marker_reg;
    logic [7:0] escape_mask_reg;

    // Frame state.
    logic                             escape_pending_reg;
    logic                             escape_pending_next;
    logic                             holding_reg;
    logic                             holding_next;
    logic [7:0]                       held_reg;
    logic [7:0]                       held_next;
    logic [7:0]                       crc_reg;
    logic [7:0]                       crc_next;
    logic [efd_pkg::LENGTH_WIDTH-1:0] count_reg;
    logic [efd_pkg::LENGTH_WIDTH-1:0] count_next;

    // Decode of the incoming byte.
    logic                             accept;
    logic                             have_byte;
    logic [7:0]                       decoded;
    logic                             escape_after;
    logic                             emit_byte;
    logic                             holding_after;
    logic [7:0]                       held_after;
    logic [7:0]                       crc_after;
    logic [efd_pkg::LENGTH_WIDTH-1:0] count_after;
    efd_pkg::status_t                 frame_status;
    logic [efd_pkg::LENGTH_WIDTH-1:0] frame_length;

    efd_pkg::result_t                     byte_result;
    efd_pkg::result_t                     status_result;
    efd_pkg::fifo_push_t                  push;
    efd_pkg::result_t                     head;
    logic                                 head_valid;
    logic [efd_pkg::FIFO_LEVEL_WIDTH-1:0] fifo_level;

    assign cfg_ready = 1'b1;

    // Room for two results guarantees that a buffer's last byte never overflows.
    assign s_axis_tready = (fifo_level
        <= efd_pkg::FIFO_LEVEL_WIDTH'(efd_pkg::FIFO_DEPTH - efd_pkg::MAX_PUSH));
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= efd_pkg::START_MARKER_RESET;
            end_marker_reg <= efd_pkg::END_MARKER_RESET;
            escape_marker_reg <= efd_pkg::ESCAPE_MARKER_RESET;
            escape_mask_reg <= efd_pkg::ESCAPE_MASK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                efd_pkg::REG_START_MARKER:  start_marker_reg <= cfg_data;
                efd_pkg::REG_END_MARKER:    end_marker_reg <= cfg_data;
                efd_pkg::REG_ESCAPE_MARKER: escape_marker_reg <= cfg_data;
                efd_pkg::REG_ESCAPE_MASK:   escape_mask_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // An escaped byte is taken as is after the mask; otherwise the framing
    // markers are dropped first, and only then is the escape marker checked.
    always_comb
    begin
        have_byte = 1'b0;
        decoded = '0;
        escape_after = escape_pending_reg;
        priority if (escape_pending_reg)
        begin
            decoded = s_axis_tdata ^ escape_mask_reg;
            have_byte = 1'b1;
            escape_after = 1'b0;
        end
        else if ((s_axis_tdata == start_marker_reg) || (s_axis_tdata == end_marker_reg))
        begin
            have_byte = 1'b0;
        end
        else if (s_axis_tdata == escape_marker_reg)
        begin
            escape_after = 1'b1;
        end
        else
        begin
            decoded = s_axis_tdata;
            have_byte = 1'b1;
        end
    end

    // A new decoded byte releases the one held back; the held byte always
    // trails by one, so the last one of a frame is the received CRC.
    always_comb
    begin
        emit_byte = have_byte && holding_reg;
        crc_after = emit_byte ? efd_pkg::crc8_update(crc_reg, held_reg) : crc_reg;
        count_after = (emit_byte && (count_reg != efd_pkg::LEN_MAX))
                      ? count_reg + 1'b1 : count_reg;
        held_after = have_byte ? decoded : held_reg;
        holding_after = holding_reg || have_byte;
    end

    always_comb
    begin
        frame_length = count_after;
        priority if (escape_after)
        begin
            frame_status = efd_pkg::STATUS_ESCAPE_AT_END;
        end
        else if (!holding_after)
        begin
            frame_status = efd_pkg::STATUS_EMPTY_FRAME;
            frame_length = '0;
        end
        else if (crc_after == held_after)
        begin
            frame_status = efd_pkg::STATUS_OK;
        end
        else
        begin
            frame_status = efd_pkg::STATUS_CRC_MISMATCH;
        end
    end

    always_comb
    begin
        byte_result.kind = efd_pkg::KIND_PAYLOAD;
        byte_result.payload_byte = held_reg;
        byte_result.status = efd_pkg::STATUS_OK;
        byte_result.payload_length = '0;
        byte_result.last = !s_axis_tlast;

        status_result.kind = efd_pkg::KIND_STATUS;
        status_result.payload_byte = '0;
        status_result.status = frame_status;
        status_result.payload_length = frame_length;
        status_result.last = 1'b1;

        push.count = accept ? (2'(emit_byte) + 2'(s_axis_tlast)) : 2'd0;
        push.first = emit_byte ? byte_result : status_result;
        push.second = status_result;
    end

    // The whole frame state returns to zero after the buffer's last byte.
    always_comb
    begin
        escape_pending_next = escape_pending_reg;
        holding_next = holding_reg;
        held_next = held_reg;
        crc_next = crc_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                escape_pending_next = 1'b0;
                holding_next = 1'b0;
                held_next = '0;
                crc_next = '0;
                count_next = '0;
            end
            else
            begin
                escape_pending_next = escape_after;
                holding_next = holding_after;
                held_next = held_after;
                crc_next = crc_after;
                count_next = count_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
            holding_reg <= 1'b0;
            held_reg <= '0;
            crc_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            escape_pending_reg <= escape_pending_next;
            holding_reg <= holding_next;
            held_reg <= held_next;
            crc_reg <= crc_next;
            count_reg <= count_next;
        end
    end

    efd_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (m_axis_tready),
        .head       (head),
        .head_valid (head_valid),
        .level      (fifo_level)
    );

    assign m_axis_tvalid = head_valid;
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;
    assign m_axis_tdata = {{efd_pkg::OUT_PAD_WIDTH{1'b0}}, head.payload_length,
                           head.status, head.payload_byte};

    // The queue never takes a byte without room for both of its results.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (fifo_level <= efd_pkg::FIFO_LEVEL_WIDTH'(
            efd_pkg::FIFO_DEPTH - efd_pkg::MAX_PUSH)))
        else $error("result queue accepted a byte without room for two results");

    // The end of a buffer leaves no frame state behind.
    a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=>
            (!escape_pending_reg && !holding_reg && (count_reg == '0) && (crc_reg == '0)))
        else $error("frame state not cleared after buffer end");

    // A status beat never carries a payload byte and always closes its step.
    a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == efd_pkg::KIND_STATUS)) |->
            (m_axis_tlast && (head.payload_byte == '0)))
        else $error("status beat with payload byte or without last");

endmodule
